// ----- hw/rtl/rebp_pkg.sv -----
// ---------------------------------------------------------------------------
// rebp_pkg
// Shared types and constants for the Rice encoder / byte packer.
// ---------------------------------------------------------------------------
package rebp_pkg;

  localparam int SYM_W = 8;
  localparam logic [7:0] SYM_MASK = 8'((1 << SYM_W) - 1);
  localparam logic [2:0] RICE_K_RESET = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ZEROS,
    ST_TAIL,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic step_zero;
    logic step_tail;
    logic step_flush;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic zero_fin;
    logic tail_fin;
    logic flush_go;
  } sts_t;

endpackage

// ----- hw/rtl/rebp_ctrl.sv -----
// ---------------------------------------------------------------------------
// rebp_ctrl
// Sequencer: load, zero run, tail bits, optional padded flush byte.
// ---------------------------------------------------------------------------
module rebp_ctrl import rebp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_ZEROS;
      end
      ST_ZEROS: begin
        if (sts.slot_free && sts.zero_fin) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        if (sts.slot_free && sts.tail_fin) begin
          state_next = sts.flush_go ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts.slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // every step waits for the output slot, whether or not it fills a byte
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_ZEROS: cmd.step_zero  = sts.slot_free;
      ST_TAIL:  cmd.step_tail  = sts.slot_free;
      ST_FLUSH: cmd.step_flush = sts.slot_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/rebp_datapath.sv -----
// ---------------------------------------------------------------------------
// rebp_datapath
// Bit accumulator, code counters, k register and output byte register.
// ---------------------------------------------------------------------------
module rebp_datapath import rebp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  input  logic [7:0] symbol,
  input  logic       last,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       padded_end
);

  logic [2:0] rice_k;
  logic [7:0] acc;        // pending bits, right-aligned
  logic [2:0] cnt;
  logic [6:0] zcnt;       // zeros left in the unary part
  logic [7:0] tbits;      // marker + remainder, left-aligned
  logic [3:0] tcnt;
  logic       last_r;
  logic [4:0] rem_bytes;  // bytes still owed for this transaction

  // load path
  logic [2:0] k_eff;
  logic [7:0] sym;
  logic [6:0] q;
  logic [7:0] low_mask;
  logic [7:0] tv;
  logic [7:0] total;
  logic [4:0] nb;

  always_comb begin
    k_eff    = (rice_k == 3'd0) ? 3'd1 : rice_k;
    sym      = symbol & SYM_MASK;
    q        = 7'(sym >> k_eff);
    low_mask = 8'((16'd1 << k_eff) - 16'd1);
    tv       = 8'(16'd1 << k_eff) | (sym & low_mask);
    total    = 8'(cnt) + 8'(q) + 8'(k_eff) + 8'd1;
    nb       = total[7:3] + 5'(last && (total[2:0] != 3'd0));
  end

  // step path
  logic [3:0] space;
  logic       zfin;
  logic       tfin;
  logic [3:0] n_z;
  logic [3:0] n_t;
  logic [3:0] n;
  logic [7:0] tail_in;
  logic [7:0] new_acc;
  logic [3:0] newc;
  logic       full;
  logic [7:0] flush_byte;
  logic       emit;
  logic [7:0] emit_byte;

  always_comb begin
    space      = 4'd8 - {1'b0, cnt};
    zfin       = zcnt <= 7'(space);
    tfin       = tcnt <= space;
    n_z        = zfin ? zcnt[3:0] : space;
    n_t        = tfin ? tcnt : space;
    n          = cmd.step_tail ? n_t : n_z;
    tail_in    = cmd.step_tail ? (tbits >> (4'd8 - n)) : 8'd0;
    new_acc    = (acc << n) | tail_in;
    newc       = {1'b0, cnt} + n;
    full       = newc == 4'd8;
    flush_byte = acc << (4'd8 - {1'b0, cnt});
    emit       = ((cmd.step_zero || cmd.step_tail) && full) || cmd.step_flush;
    emit_byte  = cmd.step_flush ? flush_byte : new_acc;
  end

  always_comb begin
    sts.slot_free = !out_valid || out_ready;
    sts.zero_fin  = zfin;
    sts.tail_fin  = tfin;
    sts.flush_go  = last_r && (({1'b0, cnt} + tcnt) != 4'd8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rice_k <= RICE_K_RESET;
    end else if (cfg_we) begin
      rice_k <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'd0;
      cnt <= 3'd0;
    end else if (cmd.step_flush || ((cmd.step_zero || cmd.step_tail) && full)) begin
      acc <= 8'd0;
      cnt <= 3'd0;
    end else if (cmd.step_zero || cmd.step_tail) begin
      acc <= new_acc;
      cnt <= newc[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zcnt      <= q;
      tbits     <= tv << (3'd7 - k_eff);
      tcnt      <= {1'b0, k_eff} + 4'd1;
      last_r    <= last;
      rem_bytes <= nb;
    end else begin
      if (cmd.step_zero) zcnt <= zcnt - 7'(n_z);
      if (cmd.step_tail) begin
        tbits <= tbits << n_t;
        tcnt  <= tcnt - n_t;
      end
      if (emit) rem_bytes <= rem_bytes - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= emit_byte;
      last_of_run <= rem_bytes == 5'd1;
      padded_end  <= cmd.step_flush;
    end
  end

endmodule

// ----- hw/rtl/rice_encoder_byte_packer_unit.sv -----
// ---------------------------------------------------------------------------
// rice_encoder_byte_packer_unit
// Golomb-Rice encoder (divisor 2^k) with MSB-first byte packing.
// ---------------------------------------------------------------------------
// One symbol at a time. A transaction runs an accept step, then a step for
// each output byte slot touched by the unary zero run, tail steps for the
// marker and remainder bits, and a flush step for the padded end byte when
// last leaves bits pending. The packer adds at most one byte's worth of bits
// per cycle, and each step also waits for the output register to be free.
// rice_k (0 acts as 1) is taken when a symbol is accepted and should be
// written only while idle.
module rice_encoder_byte_packer_unit import rebp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] symbol,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       padded_end
);

  cmd_t cmd;
  sts_t sts;

  rebp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rebp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .symbol      (symbol),
    .last        (last),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .padded_end  (padded_end)
  );

endmodule

// ----- hw/rtl/rebp_checker.sv -----
// ---------------------------------------------------------------------------
// rebp_checker
// Port-level checks for the Rice encoder / byte packer.
// ---------------------------------------------------------------------------
module rebp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic       padded_end
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(last_of_run) && $stable(padded_end))
    else $error("output changed while stalled");

  // the padded byte always closes its transaction
  a_pad_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && padded_end |-> last_of_run)
    else $error("padded byte not marked last");

  // at most seven bits are pending, so padding fills at least the LSB
  a_pad_lsb: assert property (@(posedge clk) disable iff (rst)
    out_valid && padded_end |-> !out_byte[0])
    else $error("padded byte has code bit in LSB");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind rice_encoder_byte_packer_unit rebp_checker u_rebp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .last_of_run (last_of_run),
  .padded_end  (padded_end)
);
